[hdl/pbe_pkg.sv]
// Piece bitmap engine package: command and status codes, bit masks
// and the byte helpers used by the core. No dependencies.
package pbe_pkg;

	typedef enum logic [2:0] {
		CMD_READ  = 3'd0,
		CMD_SET   = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_FILL  = 3'd3,
		CMD_PEER  = 3'd4
	} cmd_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_BADVAL = 2'd2;

	localparam logic [7:0] BIT_MASK [8] = '{8'h80, 8'h40, 8'h20, 8'h10,
		8'h08, 8'h04, 8'h02, 8'h01};
	localparam logic [7:0] BYTE_ALL  = 8'hff;
	localparam logic [7:0] BYTE_NONE = 8'h00;

	// Valid bits of byte b, given count = {full, rem}.
	function automatic logic [7:0] byte_mask(input logic [10:0] b,
		input logic [10:0] full, input logic [2:0] rem);
		logic [7:0] m;
		m = BYTE_NONE;
		if (b < full) begin
			m = BYTE_ALL;
		end else if (b == full && rem != 3'd0) begin
			m = BYTE_ALL << (4'd8 - {1'b0, rem});
		end
		return m;
	endfunction

	function automatic logic [3:0] pop8(input logic [7:0] x);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'd0, x[k]};
		end
		return n;
	endfunction

endpackage

[hdl/piece_bitmap_engine_core.sv]
// Piece bitmap engine top level: bitmap memory, held-piece counter,
// peer interest flag and the command sequencer. Depends on pbe_pkg.

// After reset the core runs a clearing pass over the bitmap memory, one byte a
// cycle, with in_ready low. Read bit, set bit, compare peer byte and unknown
// commands go through S_EXEC and S_DONE after the input transfer: the transfer
// edge reads the addressed byte, S_EXEC updates it and the counters, and S_DONE
// loads the output register once it is free. Clear all and set all step
// through the bytes in S_SWEEP, one byte a cycle, on the memory write port.
// The first command after a valid_count write, unless it is clear all or set
// all, adds S_RECOUNT, in which the read port streams the bytes through a
// popcount and accumulator to rebuild have_count. in_ready returns with
// out_valid, as S_DONE goes back to S_IDLE: a new item is taken once the
// previous result is in the output register, even if it has not been taken.
module piece_bitmap_engine_core #(
	parameter int MAX_PIECES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [12:0] bit_index,
	input  logic [7:0]  set_value,
	input  logic [7:0]  peer_byte,
	input  logic [9:0]  peer_byte_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        bit_value,
	output logic [1:0]  status,
	output logic [13:0] have_count,
	output logic        interested
);
	import pbe_pkg::*;

	localparam int MAP_BYTES = (MAX_PIECES + 7) / 8;
	localparam int MEM_DEPTH = (MAP_BYTES < 2048) ? MAP_BYTES : 2048;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int MEM_LAST  = MEM_DEPTH - 1;
	localparam int CNT_CAP   = (MAX_PIECES < 16383) ? MAX_PIECES : 16383;

	typedef enum logic [5:0] {
		S_INIT    = 6'b000001,
		S_IDLE    = 6'b000010,
		S_EXEC    = 6'b000100,
		S_SWEEP   = 6'b001000,
		S_RECOUNT = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t      state_q;
	logic [13:0] valid_count_q;
	logic        dirty_q;
	logic [11:0] ptr_q;
	logic        rc_vld_s1;
	logic [10:0] rc_idx_s1;
	logic [13:0] held_q;
	logic        flag_q;
	logic        out_valid_q;

	logic [2:0]  cmd_q;
	logic [12:0] idx_q;
	logic [7:0]  val_q;
	logic [7:0]  peer_q;
	logic [9:0]  pidx_q;
	logic        res_bit_q;
	logic [1:0]  res_status_q;
	logic        bit_value_q;
	logic [1:0]  status_q;
	logic [13:0] have_count_q;
	logic        interested_q;

	logic [7:0]  mem [MEM_DEPTH];
	logic [7:0]  rd_data_q;

	logic [13:0]       cnt;
	logic [14:0]       cnt_sum;
	logic [11:0]       nbytes;
	logic [10:0]       full_w;
	logic [2:0]        rem_w;
	logic              accept;
	logic              out_free;
	logic              load_out;
	logic              idx_ok;
	logic              bit_cur;
	logic              pidx_ok;
	logic [7:0]        want;
	logic              sweep_last;
	logic              init_last;
	logic              rc_issue;
	logic [3:0]        rc_pop;
	logic [10:0]       in_addr_w;
	logic [10:0]       idx_byte_w;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              wr_en;

	always_comb begin
		cnt = (valid_count_q > CNT_CAP[13:0]) ? CNT_CAP[13:0] : valid_count_q;
		cnt_sum = {1'b0, cnt} + 15'd7;
		nbytes = cnt_sum[14:3];
		full_w = cnt[13:3];
		rem_w = cnt[2:0];
	end

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == S_DONE) && out_free;

	assign idx_ok     = {1'b0, idx_q} < cnt;
	assign bit_cur    = |(rd_data_q & BIT_MASK[idx_q[2:0]]);
	assign pidx_ok    = {2'b00, pidx_q} < nbytes;
	assign want       = peer_q & ~rd_data_q & byte_mask({1'b0, pidx_q}, full_w, rem_w);
	assign sweep_last = (ptr_q + 12'd1) == nbytes;
	assign init_last  = ptr_q == MEM_LAST[11:0];
	assign rc_issue   = ptr_q < nbytes;
	assign rc_pop     = pop8(rd_data_q & byte_mask(rc_idx_s1, full_w, rem_w));

	assign in_addr_w = (cmd == CMD_PEER) ? {1'b0, peer_byte_index}
		: {1'b0, bit_index[12:3]};
	assign idx_byte_w = {1'b0, idx_q[12:3]};

	always_comb begin
		rd_addr = ptr_q[ADDR_W-1:0];
		wr_en = 1'b0;
		wr_addr = ptr_q[ADDR_W-1:0];
		wr_data = BYTE_NONE;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = in_addr_w[ADDR_W-1:0];
			end
			S_INIT: begin
				wr_en = 1'b1;
			end
			S_SWEEP: begin
				wr_en = 1'b1;
				wr_data = (cmd_q == CMD_FILL) ? BYTE_ALL : BYTE_NONE;
			end
			S_EXEC: begin
				wr_en = (cmd_q == CMD_SET) && idx_ok && (val_q == 8'd1);
				wr_addr = idx_byte_w[ADDR_W-1:0];
				wr_data = rd_data_q | BIT_MASK[idx_q[2:0]];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			valid_count_q <= 14'd0;
			dirty_q <= 1'b0;
			ptr_q <= 12'd0;
			rc_vld_s1 <= 1'b0;
			rc_idx_s1 <= 11'd0;
			held_q <= 14'd0;
			flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + 12'd1;
					if (init_last) begin
						ptr_q <= 12'd0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						CMD_SET: begin
							if (idx_ok && val_q == 8'd1 && !bit_cur) begin
								held_q <= held_q + 14'd1;
							end
						end
						CMD_CLEAR, CMD_FILL: begin
							held_q <= (cmd_q == CMD_FILL) ? cnt : 14'd0;
						end
						CMD_PEER: begin
							if (pidx_ok && (|want)) begin
								flag_q <= 1'b1;
							end else if (pidx_q == 10'd0) begin
								flag_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
					ptr_q <= 12'd0;
					rc_vld_s1 <= 1'b0;
					if (cmd_q == CMD_CLEAR || cmd_q == CMD_FILL) begin
						dirty_q <= 1'b0;
						state_q <= (nbytes == 12'd0) ? S_DONE : S_SWEEP;
					end else if (dirty_q) begin
						held_q <= 14'd0;
						state_q <= S_RECOUNT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SWEEP: begin
					ptr_q <= ptr_q + 12'd1;
					if (sweep_last) begin
						state_q <= S_DONE;
					end
				end
				S_RECOUNT: begin
					if (rc_vld_s1) begin
						held_q <= held_q + {10'd0, rc_pop};
					end
					rc_vld_s1 <= rc_issue;
					rc_idx_s1 <= ptr_q[10:0];
					if (rc_issue) begin
						ptr_q <= ptr_q + 12'd1;
					end else begin
						dirty_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
			if (cfg_we) begin
				valid_count_q <= cfg_wdata;
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			idx_q <= bit_index;
			val_q <= set_value;
			peer_q <= peer_byte;
			pidx_q <= peer_byte_index;
		end
		if (state_q == S_EXEC) begin
			res_bit_q <= 1'b0;
			res_status_q <= ST_OK;
			case (cmd_q)
				CMD_READ: begin
					if (!idx_ok) begin
						res_status_q <= ST_RANGE;
					end else begin
						res_bit_q <= bit_cur;
					end
				end
				CMD_SET: begin
					if (!idx_ok) begin
						res_status_q <= ST_RANGE;
					end else if (val_q > 8'd1) begin
						res_status_q <= ST_BADVAL;
					end
				end
				CMD_PEER: begin
					if (!pidx_ok) begin
						res_status_q <= ST_RANGE;
					end
				end
				default: begin
				end
			endcase
		end
		if (load_out) begin
			bit_value_q <= res_bit_q;
			status_q <= res_status_q;
			have_count_q <= held_q;
			interested_q <= flag_q;
		end
	end

	assign in_ready   = state_q == S_IDLE;
	assign out_valid  = out_valid_q;
	assign bit_value  = bit_value_q;
	assign status     = status_q;
	assign have_count = have_count_q;
	assign interested = interested_q;

endmodule

[dv/piece_map_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the piece bitmap engine: mirrors the bitmap, the valid piece
// count and the peer interest flag, predicts each result and compares it per
// field. Depends on pbe_pkg.
module piece_map_checker #(
	parameter int PIECES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [12:0] bit_index,
	input  logic [7:0]  set_value,
	input  logic [7:0]  peer_byte,
	input  logic [9:0]  peer_byte_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        bit_value,
	input  logic [1:0]  status,
	input  logic [13:0] have_count,
	input  logic        interested,
	output int          errors,
	output int          pending
);
	import pbe_pkg::*;

	localparam int MAP_BYTES = (PIECES + 7) / 8;

	typedef struct packed {
		logic        bit_value;
		logic [1:0]  status;
		logic [13:0] have_count;
		logic        interested;
	} piece_result_t;

	logic [7:0]    held_map [MAP_BYTES];
	logic [13:0]   piece_limit;
	logic          peer_wants;
	piece_result_t owed_results [$];
	int            fault_count = 0;

	function automatic int unsigned live_pieces();
		return (piece_limit > PIECES) ? PIECES : piece_limit;
	endfunction

	function automatic logic [7:0] live_mask(input int unsigned b, input int unsigned n);
		if (b < n / 8) begin
			return BYTE_ALL;
		end
		if (b == n / 8 && n % 8 != 0) begin
			return BYTE_ALL << (8 - n % 8);
		end
		return BYTE_NONE;
	endfunction

	function automatic logic [13:0] count_held();
		int unsigned n;
		int unsigned b;
		int unsigned total;
		n = live_pieces();
		total = 0;
		for (b = 0; b < (n + 7) / 8; b++) begin
			total += $countones(held_map[b] & live_mask(b, n));
		end
		return 14'(total);
	endfunction

	function automatic piece_result_t run_command(input logic [2:0] op,
		input logic [12:0] idx, input logic [7:0] val, input logic [7:0] peer,
		input logic [9:0] pos);
		piece_result_t r;
		int unsigned n;
		int unsigned nbytes;
		int unsigned b;
		r = '0;
		n = live_pieces();
		nbytes = (n + 7) / 8;
		case (op)
			CMD_READ: begin
				if (idx >= n) begin
					r.status = ST_RANGE;
				end else begin
					r.bit_value = held_map[idx[12:3]][3'd7 - idx[2:0]];
				end
			end
			CMD_SET: begin
				if (idx >= n) begin
					r.status = ST_RANGE;
				end else if (val > 8'd1) begin
					r.status = ST_BADVAL;
				end else if (val == 8'd1) begin
					held_map[idx[12:3]][3'd7 - idx[2:0]] = 1'b1;
				end
			end
			CMD_CLEAR, CMD_FILL: begin
				for (b = 0; b < nbytes; b++) begin
					held_map[b] = (op == CMD_FILL) ? BYTE_ALL : BYTE_NONE;
				end
			end
			CMD_PEER: begin
				if (pos == 10'd0) begin
					peer_wants = 1'b0;
				end
				if (pos >= nbytes) begin
					r.status = ST_RANGE;
				end else if ((peer & ~held_map[pos] & live_mask(pos, n)) != BYTE_NONE) begin
					peer_wants = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.have_count = count_held();
		r.interested = peer_wants;
		return r;
	endfunction

	task automatic note_fault(input string what, input int got, input int want);
		$display("checker: %0s: got %0d, want %0d (t=%0t)", what, got, want, $time);
		fault_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		piece_result_t want;
		if (!arst_n) begin
			held_map = '{default: BYTE_NONE};
			piece_limit = '0;
			peer_wants = 1'b0;
			owed_results.delete();
		end else begin
			if (cfg_we) begin
				piece_limit = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				owed_results.push_back(run_command(cmd, bit_index, set_value, peer_byte,
					peer_byte_index));
			end
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					note_fault("result transfer with no command pending", 1, 0);
				end else begin
					want = owed_results.pop_front();
					if (bit_value !== want.bit_value) begin
						note_fault("bit_value", bit_value, want.bit_value);
					end
					if (status !== want.status) begin
						note_fault("status", status, want.status);
					end
					if (have_count !== want.have_count) begin
						note_fault("have_count", have_count, want.have_count);
					end
					if (interested !== want.interested) begin
						note_fault("interested", interested, want.interested);
					end
				end
			end
		end
		pending <= owed_results.size();
		errors <= fault_count;
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the piece bitmap engine bench: clock, reset, valid count writes and
// command traffic with random idling on both channels.
// Depends on pbe_pkg, piece_bitmap_engine_core and piece_map_checker.
module testbench;
	import pbe_pkg::*;

	localparam int          PIECES       = 8192;
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int          LONG_HOLD    = 400;
	localparam int          SETTLE       = 8;
	localparam int          DRAIN        = 40;
	localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
	localparam logic [2:0]  CMD_SPARE_MID = 3'd6;
	localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
	localparam int          PHASES       = 7;
	localparam int          PHASE_PIECES [PHASES] = '{8192, 37, 16383, 8, 0, 1, 100};
	localparam int          PHASE_ITEMS  [PHASES] = '{120, 100, 60, 80, 30, 50, 60};
	localparam int          RANDOM_ITEMS = 500;
	localparam int          HOLD_AT      = 430;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [13:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [12:0] bit_index;
	logic [7:0]  set_value;
	logic [7:0]  peer_byte;
	logic [9:0]  peer_byte_index;
	logic        out_valid;
	logic        out_ready;
	logic        bit_value;
	logic [1:0]  status;
	logic [13:0] have_count;
	logic        interested;

	int          errors;
	int          pending;
	int          tx_idle_pct = 34;
	int          rx_idle_pct = 66;
	int          hold_asked = 0;
	int unsigned cur_pieces = 0;
	int unsigned peer_sweep = 0;
	int unsigned cycles = 0;

	piece_bitmap_engine_core #(
		.MAX_PIECES(PIECES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.bit_index(bit_index),
		.set_value(set_value),
		.peer_byte(peer_byte),
		.peer_byte_index(peer_byte_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bit_value(bit_value),
		.status(status),
		.have_count(have_count),
		.interested(interested)
	);

	piece_map_checker #(
		.PIECES(PIECES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.bit_index(bit_index),
		.set_value(set_value),
		.peer_byte(peer_byte),
		.peer_byte_index(peer_byte_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bit_value(bit_value),
		.status(status),
		.have_count(have_count),
		.interested(interested),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int served;
		served = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != served) begin
				served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic send_cmd(input logic [2:0] op, input logic [12:0] idx,
		input logic [7:0] val, input logic [7:0] peer, input logic [9:0] pos);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		bit_index <= idx;
		set_value <= val;
		peer_byte <= peer;
		peer_byte_index <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic set_pieces(input logic [13:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || !in_ready) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_pieces = (v > PIECES) ? PIECES : v;
		peer_sweep = 0;
	endtask

	task automatic send_random();
		int unsigned roll;
		int unsigned nbytes;
		logic [2:0]  op;
		logic [12:0] idx;
		logic [7:0]  val;
		logic [7:0]  peer;
		logic [9:0]  pos;
		nbytes = (cur_pieces + 7) / 8;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			op = CMD_READ;
		end else if (roll < 60) begin
			op = CMD_SET;
		end else if (roll < 85) begin
			op = CMD_PEER;
		end else if (roll < 93) begin
			op = $urandom_range(0, 1) ? CMD_CLEAR : CMD_FILL;
			if (nbytes > 128 && $urandom_range(0, 7) != 0) begin
				op = CMD_READ;
			end
		end else begin
			op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end

		roll = $urandom_range(0, 9);
		if (cur_pieces != 0 && roll < 7) begin
			idx = 13'($urandom_range(0, cur_pieces - 1));
		end else if (roll < 8) begin
			idx = 13'(cur_pieces + $urandom_range(0, 3));
		end else begin
			idx = 13'($urandom);
		end

		roll = $urandom_range(0, 9);
		if (roll < 5) begin
			val = 8'd1;
		end else if (roll < 8) begin
			val = 8'd0;
		end else begin
			val = 8'($urandom);
		end

		roll = $urandom_range(0, 9);
		if (roll < 2) begin
			peer = BYTE_NONE;
		end else if (roll < 5) begin
			peer = 8'($urandom & $urandom & $urandom);
		end else begin
			peer = 8'($urandom);
		end

		if (op == CMD_PEER && $urandom_range(0, 3) != 0) begin
			pos = 10'(peer_sweep);
			peer_sweep = (peer_sweep + 1 >= nbytes) ? 0 : peer_sweep + 1;
		end else if ($urandom_range(0, 1) != 0) begin
			pos = 10'($urandom_range(0, 1023));
		end else begin
			pos = 10'(nbytes + $urandom_range(0, 2));
		end

		send_cmd(op, idx, val, peer, pos);
	endtask

	initial begin
		int p;
		int k;
		int sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = '0;
		bit_index = '0;
		set_value = '0;
		peer_byte = '0;
		peer_byte_index = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// partial last byte: 21 pieces in 3 bytes
		set_pieces(14'd21);
		send_cmd(CMD_READ, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_SET, 13'd0, 8'd1, 8'h00, 10'd0);
		send_cmd(CMD_READ, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_SET, 13'd20, 8'd1, 8'h00, 10'd0);
		send_cmd(CMD_SET, 13'd21, 8'd1, 8'h00, 10'd0);
		send_cmd(CMD_SET, 13'd8191, 8'd255, 8'h00, 10'd0);
		send_cmd(CMD_SET, 13'd5, 8'd2, 8'h00, 10'd0);
		send_cmd(CMD_SET, 13'd6, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_READ, 13'd8191, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'h80, 10'd0);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'h07, 10'd2);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'hff, 10'd3);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'hff, 10'd1);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'h00, 10'd1023);
		send_cmd(CMD_FILL, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_CLEAR, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_SPARE_LO, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_SPARE_HI, 13'd8191, 8'd255, 8'hff, 10'd1023);

		// whole last byte: 16 pieces in 2 bytes
		set_pieces(14'd16);
		send_cmd(CMD_FILL, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'hff, 10'd0);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'h01, 10'd1);
		send_cmd(CMD_CLEAR, 13'd0, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_PEER, 13'd0, 8'd0, 8'h01, 10'd1);
		send_cmd(CMD_SET, 13'd15, 8'd1, 8'h00, 10'd0);
		send_cmd(CMD_READ, 13'd15, 8'd0, 8'h00, 10'd0);
		send_cmd(CMD_SPARE_MID, 13'd0, 8'd0, 8'h00, 10'd0);

		sent = 0;
		for (p = 0; p < PHASES; p++) begin
			set_pieces(14'(PHASE_PIECES[p]));
			for (k = 0; k < PHASE_ITEMS[p]; k++) begin
				if (sent < RANDOM_ITEMS / 3) begin
					tx_idle_pct = 34;
					rx_idle_pct = 66;
				end else if (sent < 2 * RANDOM_ITEMS / 3) begin
					tx_idle_pct = 66;
					rx_idle_pct = 34;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				if (sent == HOLD_AT) begin
					hold_asked <= hold_asked + 1;
				end
				send_random();
				sent++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
